// ===== src/telnet_stream_parser_macros.svh =====
// assertion macros for the telnet stream parser
// used by the top level only, expects clk and arst_n in scope
`ifndef TELNET_STREAM_PARSER_MACROS_SVH
`define TELNET_STREAM_PARSER_MACROS_SVH

// same-cycle implication, checked outside reset
`define TSP_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define TSP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/tsp_pkg.sv =====
// shared types and codes for the telnet stream parser
// no dependencies
`timescale 1ns / 1ps

package tsp_pkg;

	localparam logic [7:0] CODE_IAC  = 8'hFF;
	localparam logic [7:0] CODE_SB   = 8'hFA;
	localparam logic [7:0] CODE_SE   = 8'hF0;
	localparam logic [7:0] CODE_WILL = 8'hFB;
	localparam logic [7:0] CODE_DONT = 8'hFE;

	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [2:0] {
		EV_DATA    = 3'd0,
		EV_CMD     = 3'd1,
		EV_NEG     = 3'd2,
		EV_SB_BYTE = 3'd3,
		EV_SB_END  = 3'd4
	} ev_kind_t;

	typedef struct packed {
		logic [7:0] option;
		logic [7:0] value;
		ev_kind_t   kind;
	} event_t;

endpackage

// ===== src/tsp_front.sv =====
// front end: takes received bytes and runs the iac parser state machine
// depends on tsp_pkg; pushes at most one event word per byte into the queue
`timescale 1ns / 1ps

module tsp_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       rx_byte,
	input  logic             queue_full,
	output logic             ev_push,
	output tsp_pkg::event_t  ev
);

	typedef enum logic [5:0] {
		ST_DATA     = 6'b000001,
		ST_IAC      = 6'b000010,
		ST_NEG_OPT  = 6'b000100,
		ST_SB_OPT   = 6'b001000,
		ST_SB_DATA  = 6'b010000,
		ST_SB_IAC   = 6'b100000
	} state_t;

	state_t     state_q, state_d;
	logic [7:0] pend_cmd_q, pend_cmd_d;
	logic [7:0] sub_opt_q, sub_opt_d;
	logic       emit;
	logic       accept;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;
	assign ev_push  = accept && emit;

	always_comb begin
		state_d    = state_q;
		pend_cmd_d = pend_cmd_q;
		sub_opt_d  = sub_opt_q;
		emit       = 1'b0;
		ev.kind    = tsp_pkg::EV_DATA;
		ev.value   = 8'h00;
		ev.option  = 8'h00;
		unique case (state_q)
			ST_IAC: begin
				state_d = ST_DATA;
				priority if (rx_byte == tsp_pkg::CODE_IAC) begin
					emit     = 1'b1;
					ev.value = tsp_pkg::CODE_IAC;
				end else if (rx_byte == tsp_pkg::CODE_SB) begin
					state_d = ST_SB_OPT;
				end else if (rx_byte == tsp_pkg::CODE_SE) begin
					state_d = ST_DATA;
				end else if (rx_byte >= tsp_pkg::CODE_WILL && rx_byte <= tsp_pkg::CODE_DONT) begin
					pend_cmd_d = rx_byte;
					state_d    = ST_NEG_OPT;
				end else begin
					emit     = 1'b1;
					ev.kind  = tsp_pkg::EV_CMD;
					ev.value = rx_byte;
				end
			end
			ST_NEG_OPT: begin
				state_d   = ST_DATA;
				emit      = 1'b1;
				ev.kind   = tsp_pkg::EV_NEG;
				ev.value  = pend_cmd_q;
				ev.option = rx_byte;
			end
			ST_SB_OPT: begin
				sub_opt_d = rx_byte;
				state_d   = ST_SB_DATA;
			end
			ST_SB_DATA: begin
				if (rx_byte == tsp_pkg::CODE_IAC) begin
					state_d = ST_SB_IAC;
				end else begin
					emit      = 1'b1;
					ev.kind   = tsp_pkg::EV_SB_BYTE;
					ev.value  = rx_byte;
					ev.option = sub_opt_q;
				end
			end
			ST_SB_IAC: begin
				state_d = ST_SB_DATA;
				priority if (rx_byte == tsp_pkg::CODE_IAC) begin
					emit      = 1'b1;
					ev.kind   = tsp_pkg::EV_SB_BYTE;
					ev.value  = tsp_pkg::CODE_IAC;
					ev.option = sub_opt_q;
				end else if (rx_byte == tsp_pkg::CODE_SE) begin
					state_d   = ST_DATA;
					emit      = 1'b1;
					ev.kind   = tsp_pkg::EV_SB_END;
					ev.option = sub_opt_q;
				end else begin
					// unknown code inside a subnegotiation is dropped
					state_d = ST_SB_DATA;
				end
			end
			default: begin
				// data state, also catches any illegal encoding
				if (rx_byte == tsp_pkg::CODE_IAC) begin
					state_d = ST_IAC;
				end else begin
					state_d  = ST_DATA;
					emit     = 1'b1;
					ev.value = rx_byte;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_DATA;
			pend_cmd_q <= tsp_pkg::CODE_IAC;
			sub_opt_q  <= 8'h00;
		end else if (accept) begin
			state_q    <= state_d;
			pend_cmd_q <= pend_cmd_d;
			sub_opt_q  <= sub_opt_d;
		end
	end

endmodule

// ===== src/tsp_fifo.sv =====
// short event queue between parser front end and output stage
// depends on tsp_pkg; flop-based, one push and one pop per cycle
`timescale 1ns / 1ps

module tsp_fifo #(
	parameter int DEPTH = tsp_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  tsp_pkg::event_t  din,
	output logic             full,
	input  logic             pop,
	output logic             out_valid,
	output tsp_pkg::event_t  dout
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	tsp_pkg::event_t  mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		ptr_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full      = (count_q == CNT_W'(DEPTH));
	assign out_valid = (count_q != '0);
	assign dout      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== src/tsp_back.sv =====
// back end: pulls event words from the queue into the output register
// depends on tsp_pkg; packs value and option into tdata, kind into tuser
`timescale 1ns / 1ps

module tsp_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  tsp_pkg::event_t  q_data,
	output logic             q_pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [15:0]      out_data,
	output logic [2:0]       out_user
);

	logic             valid_q;
	tsp_pkg::event_t  ev_q;
	logic             load;

	// output register is free when empty or being drained
	assign load      = !valid_q || out_ready;
	assign q_pop     = q_valid && load;
	assign out_valid = valid_q;
	assign out_data  = {ev_q.option, ev_q.value};
	assign out_user  = ev_q.kind;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			ev_q <= q_data;
		end
	end

endmodule

// ===== src/telnet_stream_parser.sv =====
// channel  dir  handshake                     tdata                      tuser
// rx byte  in   s_axis_tvalid/s_axis_tready   [7:0] rx_byte              -
// event    out  m_axis_tvalid/m_axis_tready   [7:0] value [15:8] option  [2:0] kind
//
// one byte accepted per cycle while the queue is not full, each in one parser step in the front end
// an event passes through the queue and then the output register before it is on the output
// async reset clears parser state, queue pointers and output valid; no clearing pass
// output stalls are absorbed by a QUEUE_DEPTH-word queue plus the output register,
// s_axis_tready falls only when the queue is full
// depends on tsp_pkg, tsp_front, tsp_fifo, tsp_back and the macro header
`timescale 1ns / 1ps

`include "telnet_stream_parser_macros.svh"

module telnet_stream_parser #(
	parameter int QUEUE_DEPTH = tsp_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [7:0] event_value, [15:8] event_option
	output logic [2:0]  m_axis_tuser    // [2:0] event_kind
);

	logic             ev_push;
	tsp_pkg::event_t  ev;
	logic             q_full;
	logic             q_pop;
	logic             q_valid;
	tsp_pkg::event_t  q_data;

	tsp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.rx_byte    (s_axis_tdata),
		.queue_full (q_full),
		.ev_push    (ev_push),
		.ev         (ev)
	);

	tsp_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (ev_push),
		.din       (ev),
		.full      (q_full),
		.pop       (q_pop),
		.out_valid (q_valid),
		.dout      (q_data)
	);

	tsp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser)
	);

	`TSP_ASSERT_SAME(a_full_has_word, !s_axis_tready, q_valid, "queue full but reports no word")
	`TSP_ASSERT_NEXT(a_push_lands, ev_push, q_valid, "pushed word missing from queue")
	`TSP_ASSERT_NEXT(a_idle_out_loads, q_valid && !m_axis_tvalid, m_axis_tvalid, "output register failed to load")

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for telnet_stream_parser: directed telnet sequences, then random traffic
// a scoreboard class predicts each event; random stalls on both sides; depends on tsp_pkg and the rtl
`timescale 1ns / 1ps

module testbench;

	localparam logic [7:0] CODE_NOP   = 8'hF1;
	localparam logic [7:0] OPT_BINARY = 8'h00;
	localparam logic [7:0] OPT_TTYPE  = 8'h18;

	localparam int BYTE_TARGET   = 1850;
	localparam int QUIET_FROM    = 600;
	localparam int QUIET_TO      = 800;
	localparam int HOLD_AT       = 1000;
	localparam int HOLD_CYCLES   = 300;
	localparam int DRAIN_LIMIT   = 20000;

	typedef enum logic [2:0] {
		PS_DATA    = 3'd0,
		PS_IAC     = 3'd1,
		PS_NEG_OPT = 3'd2,
		PS_SB_OPT  = 3'd3,
		PS_SB_DATA = 3'd4,
		PS_SB_IAC  = 3'd5
	} parse_state_t;

	class telnet_scoreboard;
		parse_state_t    state;
		logic [7:0]      pending_cmd;
		logic [7:0]      sub_opt;
		tsp_pkg::event_t expected_events [$];
		int              errors;

		function new();
			state = PS_DATA;
			pending_cmd = tsp_pkg::CODE_IAC;
			sub_opt = 8'h00;
			errors = 0;
		endfunction

		task report(input string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		function void push_event(input tsp_pkg::ev_kind_t kind, input logic [7:0] value,
				input logic [7:0] option);
			tsp_pkg::event_t ev;
			ev.kind = kind;
			ev.value = value;
			ev.option = option;
			expected_events.push_back(ev);
		endfunction

		function int pending();
			return expected_events.size();
		endfunction

		// advance the parser by one accepted word and queue any event it gives
		function void note_byte(input logic [7:0] b);
			case (state)
				PS_IAC: begin
					if (b == tsp_pkg::CODE_IAC) begin
						state = PS_DATA;
						push_event(tsp_pkg::EV_DATA, tsp_pkg::CODE_IAC, 8'h00);
					end else if (b == tsp_pkg::CODE_SB) begin
						state = PS_SB_OPT;
					end else if (b == tsp_pkg::CODE_SE) begin
						state = PS_DATA;
					end else if (b >= tsp_pkg::CODE_WILL && b <= tsp_pkg::CODE_DONT) begin
						pending_cmd = b;
						state = PS_NEG_OPT;
					end else begin
						state = PS_DATA;
						push_event(tsp_pkg::EV_CMD, b, 8'h00);
					end
				end
				PS_NEG_OPT: begin
					state = PS_DATA;
					push_event(tsp_pkg::EV_NEG, pending_cmd, b);
				end
				PS_SB_OPT: begin
					sub_opt = b;
					state = PS_SB_DATA;
				end
				PS_SB_DATA: begin
					if (b == tsp_pkg::CODE_IAC)
						state = PS_SB_IAC;
					else
						push_event(tsp_pkg::EV_SB_BYTE, b, sub_opt);
				end
				PS_SB_IAC: begin
					if (b == tsp_pkg::CODE_IAC) begin
						state = PS_SB_DATA;
						push_event(tsp_pkg::EV_SB_BYTE, tsp_pkg::CODE_IAC, sub_opt);
					end else if (b == tsp_pkg::CODE_SE) begin
						state = PS_DATA;
						push_event(tsp_pkg::EV_SB_END, 8'h00, sub_opt);
					end else begin
						// unexpected code inside a subnegotiation is dropped
						state = PS_SB_DATA;
					end
				end
				default: begin
					if (b == tsp_pkg::CODE_IAC) begin
						state = PS_IAC;
					end else begin
						state = PS_DATA;
						push_event(tsp_pkg::EV_DATA, b, 8'h00);
					end
				end
			endcase
		endfunction

		task check_event(input tsp_pkg::ev_kind_t kind, input logic [7:0] value,
				input logic [7:0] option);
			tsp_pkg::event_t exp_ev;
			if (expected_events.size() == 0) begin
				report($sformatf("unexpected event kind %0d value %02h option %02h",
					kind, value, option));
			end else begin
				exp_ev = expected_events.pop_front();
				if (kind !== exp_ev.kind)
					report($sformatf("kind %0d, expected %0d", kind, exp_ev.kind));
				if (value !== exp_ev.value)
					report($sformatf("value %02h, expected %02h", value, exp_ev.value));
				if (option !== exp_ev.option)
					report($sformatf("option %02h, expected %02h", option, exp_ev.option));
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;

	telnet_scoreboard sb = new();
	int bytes_sent = 0;
	bit no_idle = 0;
	bit hold_request = 0;

	telnet_stream_parser u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = no_idle ? 0 : pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_byte(b);
		bytes_sent++;
	endtask

	task automatic send_random_sequence();
		int pick;
		int n;
		int r;
		pick = $urandom_range(0, 99);
		if (pick < 25) begin
			n = $urandom_range(1, 6);
			repeat (n) send_byte(8'($urandom_range(0, tsp_pkg::CODE_DONT)));
		end else if (pick < 32) begin
			send_byte(tsp_pkg::CODE_IAC);
			send_byte(tsp_pkg::CODE_IAC);
		end else if (pick < 42) begin
			send_byte(tsp_pkg::CODE_IAC);
			if ($urandom_range(0, 1))
				send_byte(8'($urandom_range(0, tsp_pkg::CODE_SE - 1)));
			else
				send_byte(8'($urandom_range(tsp_pkg::CODE_SE + 1, tsp_pkg::CODE_SB - 1)));
		end else if (pick < 60) begin
			send_byte(tsp_pkg::CODE_IAC);
			send_byte(8'($urandom_range(tsp_pkg::CODE_WILL, tsp_pkg::CODE_DONT)));
			send_byte(8'($urandom_range(0, 255)));
		end else if (pick < 90) begin
			send_byte(tsp_pkg::CODE_IAC);
			send_byte(tsp_pkg::CODE_SB);
			send_byte(8'($urandom_range(0, 255)));
			n = $urandom_range(0, 8);
			repeat (n) begin
				r = $urandom_range(0, 99);
				if (r < 10) begin
					send_byte(tsp_pkg::CODE_IAC);
					send_byte(tsp_pkg::CODE_IAC);
				end else if (r < 15) begin
					send_byte(tsp_pkg::CODE_IAC);
					send_byte(8'($urandom_range(0, tsp_pkg::CODE_SE - 1)));
				end else begin
					send_byte(8'($urandom_range(0, tsp_pkg::CODE_DONT)));
				end
			end
			// now and then leave the subnegotiation open
			if ($urandom_range(0, 9) != 0) begin
				send_byte(tsp_pkg::CODE_IAC);
				send_byte(tsp_pkg::CODE_SE);
			end
		end else begin
			n = $urandom_range(1, 3);
			repeat (n) send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	// receiver: checks events and stalls at random
	initial begin
		int stall_left;
		stall_left = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_event(tsp_pkg::ev_kind_t'(m_axis_tuser), m_axis_tdata[7:0],
					m_axis_tdata[15:8]);
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0 && !no_idle) begin
				stall_left = pick_gap();
			end
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		logic [7:0] directed [$];
		bit quiet_done;
		bit hold_done;
		int guard;
		directed = {8'h00, 8'h7F, 8'h80, tsp_pkg::CODE_DONT,
			tsp_pkg::CODE_IAC, tsp_pkg::CODE_IAC,
			tsp_pkg::CODE_IAC, CODE_NOP,
			tsp_pkg::CODE_IAC, 8'h00,
			tsp_pkg::CODE_IAC, tsp_pkg::CODE_WILL, OPT_BINARY,
			tsp_pkg::CODE_IAC, tsp_pkg::CODE_DONT, tsp_pkg::CODE_IAC,
			tsp_pkg::CODE_IAC, tsp_pkg::CODE_SE,
			tsp_pkg::CODE_IAC, tsp_pkg::CODE_SB, OPT_TTYPE, 8'h00,
			tsp_pkg::CODE_IAC, tsp_pkg::CODE_IAC, 8'h41,
			tsp_pkg::CODE_IAC, CODE_NOP, tsp_pkg::CODE_IAC, tsp_pkg::CODE_SE};
		quiet_done = 0;
		hold_done = 0;
		guard = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 8'h00;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_byte(directed[i]);

		while (bytes_sent < BYTE_TARGET) begin
			if (!quiet_done && bytes_sent >= QUIET_FROM)
				no_idle = 1'b1;
			if (!quiet_done && bytes_sent >= QUIET_TO) begin
				no_idle = 1'b0;
				quiet_done = 1'b1;
			end
			// long receiver hold while words keep coming, so the input stalls
			if (!hold_done && bytes_sent >= HOLD_AT) begin
				hold_request = 1'b1;
				hold_done = 1'b1;
			end
			send_random_sequence();
		end
		s_axis_tvalid <= 1'b0;

		while (sb.pending() > 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);
		if (sb.pending() > 0)
			sb.report($sformatf("%0d events never produced", sb.pending()));

		if (sb.errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

	initial begin
		#(5_000_000);
		$display("timeout");
		$display("testbench: errors");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+src
src/tsp_pkg.sv
src/tsp_front.sv
src/tsp_fifo.sv
src/tsp_back.sv
src/telnet_stream_parser.sv
verif/testbench.sv
